>>> sv/dss_pkg.sv
package dss_pkg;

    // Operation codes carried in the mode field
    typedef enum logic [1:0] {
        MODE_INIT = 2'd0,
        MODE_PUSH = 2'd1,
        MODE_POP  = 2'd2,
        MODE_PEEK = 2'd3
    } mode_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2,
        STATUS_EMPTY     = 2'd3
    } status_t;

    // Stack select
    localparam logic SIDE_LOWER = 1'b0;
    localparam logic SIDE_UPPER = 1'b1;

    // Controller states
    typedef enum logic {
        CTL_IDLE,
        CTL_RESP
    } ctl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // execute the accepted operation
    } dss_cmd_t;

endpackage

>>> sv/dss_ctrl.sv
module dss_ctrl
    import dss_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output dss_cmd_t cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd.load   = 1'b0;
        unique case (state_reg)
            CTL_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = CTL_RESP;
                end
            end
            CTL_RESP: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = CTL_IDLE;
                end
            end
            default: begin
                state_next = CTL_IDLE;
            end
        endcase
    end

endmodule

>>> sv/dss_datapath.sv
module dss_datapath
    import dss_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  dss_cmd_t           cmd,
    input  logic [1:0]         mode,
    input  logic               which_stack,
    input  logic signed [31:0] push_value,
    output logic [1:0]         status,
    output logic signed [31:0] top_value,
    output logic               is_empty,
    output logic               is_full
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EXT_W  = (WORD_BITS > 32) ? WORD_BITS : 32;
    localparam logic [CNT_W:0] DEPTH_SUM = (CNT_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    logic [WORD_BITS-1:0] mem [DEPTH];

    logic [CNT_W-1:0] lower_reg, lower_next;
    logic [CNT_W-1:0] upper_reg, upper_next;

    logic [1:0]           status_reg;
    logic                 empty_reg;
    logic                 full_reg;
    logic                 peek_ok_reg;
    logic [WORD_BITS-1:0] rd_data_reg;

    logic [CNT_W:0]       sum_now, sum_after;
    logic                 full_now;
    logic [CNT_W-1:0]     cnt_now, cnt_after;
    logic [1:0]           status_next;
    logic                 peek_ok;
    logic                 wr_en;
    logic [CNT_W-1:0]     wr_pos, rd_pos;
    logic [EXT_W-1:0]     push_ext, rd_ext;
    logic [WORD_BITS-1:0] wr_data;

    assign sum_now  = {1'b0, lower_reg} + {1'b0, upper_reg};
    assign full_now = (sum_now >= DEPTH_SUM);
    assign cnt_now  = (which_stack == SIDE_UPPER) ? upper_reg : lower_reg;

    always_comb begin
        lower_next  = lower_reg;
        upper_next  = upper_reg;
        status_next = STATUS_OK;
        peek_ok     = 1'b0;
        wr_en       = 1'b0;
        unique case (mode_t'(mode))
            MODE_INIT: begin
                lower_next = '0;
                upper_next = '0;
            end
            MODE_PUSH: begin
                if (full_now) begin
                    status_next = STATUS_OVERFLOW;
                end else begin
                    wr_en = 1'b1;
                    if (which_stack == SIDE_UPPER) begin
                        upper_next = upper_reg + ONE_CNT;
                    end else begin
                        lower_next = lower_reg + ONE_CNT;
                    end
                end
            end
            MODE_POP: begin
                if (cnt_now == '0) begin
                    status_next = STATUS_UNDERFLOW;
                end else if (which_stack == SIDE_UPPER) begin
                    upper_next = upper_reg - ONE_CNT;
                end else begin
                    lower_next = lower_reg - ONE_CNT;
                end
            end
            MODE_PEEK: begin
                if (cnt_now == '0) begin
                    status_next = STATUS_EMPTY;
                end else begin
                    peek_ok = 1'b1;
                end
            end
            default: begin
                status_next = STATUS_OK;
            end
        endcase
    end

    assign sum_after = {1'b0, lower_next} + {1'b0, upper_next};
    assign cnt_after = (which_stack == SIDE_UPPER) ? upper_next : lower_next;

    // Lower stack grows up from entry 0, upper stack down from the top entry
    assign wr_pos = (which_stack == SIDE_UPPER) ? (DEPTH_CNT - ONE_CNT - upper_reg)
                                                : lower_reg;
    assign rd_pos = (which_stack == SIDE_UPPER) ? (DEPTH_CNT - upper_reg)
                                                : (lower_reg - ONE_CNT);

    assign push_ext = EXT_W'($unsigned(push_value));
    assign wr_data  = push_ext[WORD_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_reg <= '0;
            upper_reg <= '0;
        end else if (cmd.load) begin
            lower_reg <= lower_next;
            upper_reg <= upper_next;
        end
    end

    // Result registers, payload only
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            status_reg  <= status_next;
            empty_reg   <= (cnt_after == '0);
            full_reg    <= (sum_after >= DEPTH_SUM);
            peek_ok_reg <= peek_ok;
        end
    end

    // Word store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            if (wr_en) begin
                mem[wr_pos[ADDR_W-1:0]] <= wr_data;
            end
            rd_data_reg <= mem[rd_pos[ADDR_W-1:0]];
        end
    end

    assign rd_ext    = EXT_W'($signed(rd_data_reg));
    assign status    = status_reg;
    assign top_value = peek_ok_reg ? $signed(rd_ext[31:0]) : 32'sd0;
    assign is_empty  = empty_reg;
    assign is_full   = full_reg;

endmodule

>>> sv/dual_stack_shared_array_top.sv
// Two stacks in one word store: lower stack grows up, upper stack grows down.
// The result is valid in the cycle after the input transfer.
// It takes no new item before the last result is taken; the controller holds s_ready
// low from the input transfer until the result transfer completes.
// Reset (aresetn low, synchronous): both stacks empty, no result pending;
// the word store is not cleared and needs no clearing pass.
module dual_stack_shared_array_top
    import dss_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic               s_which_stack,
    input  logic signed [31:0] s_push_value,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_top_value,
    output logic               m_is_empty,
    output logic               m_is_full
);

    // Command from the controller: load fires on the input transfer, when
    // the datapath updates counts, writes/reads the store and latches the
    // result fields.
    dss_cmd_t cmd;

    // Controller: idle accepts, then holds the result until it is taken.
    dss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Datapath: stack counts, shared word store, result registers.
    // Input fields are sampled in the transfer cycle only, so no input
    // register is needed.
    dss_datapath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .mode        (s_mode),
        .which_stack (s_which_stack),
        .push_value  (s_push_value),
        .status      (m_status),
        .top_value   (m_top_value),
        .is_empty    (m_is_empty),
        .is_full     (m_is_full)
    );

endmodule

>>> sim/dss_stack_checker.sv
`timescale 1ns / 100ps

module dss_stack_checker
    import dss_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic        s_which_stack,
    input  logic [31:0] s_push_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [31:0] m_top_value,
    input  logic        m_is_empty,
    input  logic        m_is_full,
    output int          mismatch_count,
    output int          results_pending,
    output int          overflow_hits,
    output int          underflow_hits,
    output int          empty_hits,
    output int          full_hits
);

    typedef struct packed {
        status_t     status;
        logic [31:0] top_value;
        logic        is_empty;
        logic        is_full;
    } stack_result_t;

    // Shadow of the shared store and both fill levels
    logic [31:0]   stack_mem [DEPTH];
    int unsigned   lower_fill;
    int unsigned   upper_fill;
    stack_result_t awaited_results [$];
    stack_result_t want;

    function automatic stack_result_t apply_stack_op(mode_t op, logic side,
                                                     logic [31:0] value);
        stack_result_t r;
        int unsigned   used;
        r.status    = STATUS_OK;
        r.top_value = '0;
        used = (side == SIDE_UPPER) ? upper_fill : lower_fill;
        case (op)
            MODE_INIT: begin
                lower_fill = 0;
                upper_fill = 0;
            end
            MODE_PUSH: begin
                if (lower_fill + upper_fill >= DEPTH) begin
                    r.status = STATUS_OVERFLOW;
                end else if (side == SIDE_LOWER) begin
                    stack_mem[lower_fill] = value;
                    lower_fill++;
                end else begin
                    stack_mem[DEPTH - 1 - upper_fill] = value;
                    upper_fill++;
                end
            end
            MODE_POP: begin
                if (used == 0) begin
                    r.status = STATUS_UNDERFLOW;
                end else if (side == SIDE_LOWER) begin
                    lower_fill--;
                end else begin
                    upper_fill--;
                end
            end
            MODE_PEEK: begin
                if (used == 0) begin
                    r.status = STATUS_EMPTY;
                end else if (side == SIDE_LOWER) begin
                    r.top_value = stack_mem[lower_fill - 1];
                end else begin
                    r.top_value = stack_mem[DEPTH - upper_fill];
                end
            end
        endcase
        r.is_empty = (((side == SIDE_UPPER) ? upper_fill : lower_fill) == 0);
        r.is_full  = (lower_fill + upper_fill >= DEPTH);
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            lower_fill     = 0;
            upper_fill     = 0;
            awaited_results.delete();
            mismatch_count = 0;
            overflow_hits  = 0;
            underflow_hits = 0;
            empty_hits     = 0;
            full_hits      = 0;
        end else begin
            // results first: a result never belongs to an input of the same edge
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result: status %0d top_value %0d",
                           m_status, $signed(m_top_value));
                    mismatch_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        mismatch_count++;
                    end
                    if (m_top_value !== want.top_value) begin
                        $error("top_value: expected %0d, got %0d",
                               $signed(want.top_value), $signed(m_top_value));
                        mismatch_count++;
                    end
                    if (m_is_empty !== want.is_empty) begin
                        $error("is_empty: expected %0d, got %0d", want.is_empty, m_is_empty);
                        mismatch_count++;
                    end
                    if (m_is_full !== want.is_full) begin
                        $error("is_full: expected %0d, got %0d", want.is_full, m_is_full);
                        mismatch_count++;
                    end
                    if (want.status == STATUS_OVERFLOW)  overflow_hits++;
                    if (want.status == STATUS_UNDERFLOW) underflow_hits++;
                    if (want.status == STATUS_EMPTY)     empty_hits++;
                    if (want.is_full)                    full_hits++;
                end
            end
            if (s_valid && s_ready) begin
                awaited_results.push_back(apply_stack_op(mode_t'(s_mode), s_which_stack,
                                                         s_push_value));
            end
        end
        results_pending <= awaited_results.size();
    end

endmodule

>>> sim/tb_dual_stack_shared_array_top.sv
`timescale 1ns / 100ps

module tb_dual_stack_shared_array_top;
    import dss_pkg::*;

    localparam int DEPTH = 64;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_mode;
    logic               s_which_stack;
    logic signed [31:0] s_push_value;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_status;
    logic signed [31:0] m_top_value;
    logic               m_is_empty;
    logic               m_is_full;

    int mismatch_count;
    int results_pending;
    int overflow_hits;
    int underflow_hits;
    int empty_hits;
    int full_hits;

    // Idle odds in percent per cycle, per side
    int send_idle_pct;
    int recv_idle_pct;
    // Transfers sent, indexed by operation
    int ops_sent [4];

    dual_stack_shared_array_top #(
        .DEPTH     (DEPTH),
        .WORD_BITS (32)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_which_stack (s_which_stack),
        .s_push_value  (s_push_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_top_value   (m_top_value),
        .m_is_empty    (m_is_empty),
        .m_is_full     (m_is_full)
    );

    // Watches both channels, predicts every result and compares it
    dss_stack_checker #(
        .DEPTH (DEPTH)
    ) u_stack_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_which_stack   (s_which_stack),
        .s_push_value    (s_push_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_top_value     (m_top_value),
        .m_is_empty      (m_is_empty),
        .m_is_full       (m_is_full),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending),
        .overflow_hits   (overflow_hits),
        .underflow_hits  (underflow_hits),
        .empty_hits      (empty_hits),
        .full_hits       (full_hits)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 0;
    end

    // Receiver back-pressure: a fresh coin every cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // One transfer on the input channel. Random gaps go in front; valid is
    // only dropped inside a gap, so back-to-back transfers keep it high.
    task automatic send_op(input mode_t op, input logic side, input logic [31:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= op;
        s_which_stack <= side;
        s_push_value  <= value;
        do @(posedge aclk); while (!s_ready);
        ops_sent[op]++;
    endtask

    // Hold the sender off until every awaited result has come back.
    // The count is a registered copy of the queue size, hence the leading edge.
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_pending != 0);
    endtask

    // Random traffic in runs. Each run picks a push bias (filling, balanced or
    // draining) and a side bias, so the two tops meet often, overflow is hit,
    // and draining runs walk both stacks back to underflow.
    task automatic send_random_ops(input int count);
        int    left;
        int    run_len;
        int    push_pct;
        int    lower_pct;
        int    pick;
        mode_t op;
        logic  side;
        left = count;
        while (left > 0) begin
            run_len = $urandom_range(20, 90);
            if (run_len > left) run_len = left;
            case ($urandom_range(0, 2))
                0: push_pct = 85;
                1: push_pct = 50;
                default: push_pct = 20;
            endcase
            lower_pct = $urandom_range(10, 90);
            repeat (run_len) begin
                pick = $urandom_range(0, 99);
                // a rare reinit; pop and peek split what push leaves over
                if (pick < 2) op = MODE_INIT;
                else if (pick < 2 + push_pct) op = MODE_PUSH;
                else if (pick[0]) op = MODE_POP;
                else op = MODE_PEEK;
                side = ($urandom_range(0, 99) < lower_pct) ? SIDE_LOWER : SIDE_UPPER;
                // push_value is random in every mode: it must be ignored there
                send_op(op, side, $urandom());
            end
            left -= run_len;
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_mode        = MODE_INIT;
        s_which_stack = SIDE_LOWER;
        s_push_value  = '0;
        m_ready       = 1'b0;
        send_idle_pct = 38;
        recv_idle_pct = 64;
        ops_sent      = '{default: 0};

        // Synchronous reset held, then released for good
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed part ----
        // Both stacks empty straight out of reset: peek reports empty,
        // pop reports underflow.
        send_op(MODE_PEEK, SIDE_LOWER, $urandom());
        send_op(MODE_POP,  SIDE_LOWER, $urandom());
        send_op(MODE_PEEK, SIDE_UPPER, $urandom());
        send_op(MODE_POP,  SIDE_UPPER, $urandom());
        // Word extremes, one per stack, read back from each side
        send_op(MODE_PUSH, SIDE_LOWER, 32'h7FFF_FFFF);
        send_op(MODE_PUSH, SIDE_UPPER, 32'h8000_0000);
        send_op(MODE_PEEK, SIDE_LOWER, $urandom());
        send_op(MODE_PEEK, SIDE_UPPER, $urandom());
        send_op(MODE_PUSH, SIDE_LOWER, 32'hFFFF_FFFF);
        send_op(MODE_PUSH, SIDE_UPPER, 32'h0000_0000);
        send_op(MODE_PEEK, SIDE_LOWER, $urandom());
        send_op(MODE_PEEK, SIDE_UPPER, $urandom());
        // Pop back to the first entries and look at them again
        send_op(MODE_POP,  SIDE_LOWER, $urandom());
        send_op(MODE_POP,  SIDE_UPPER, $urandom());
        send_op(MODE_PEEK, SIDE_LOWER, $urandom());
        send_op(MODE_PEEK, SIDE_UPPER, $urandom());
        // Reinit with entries present: both stacks must read empty after it
        send_op(MODE_INIT, SIDE_UPPER, $urandom());
        send_op(MODE_PEEK, SIDE_LOWER, $urandom());
        send_op(MODE_PEEK, SIDE_UPPER, $urandom());
        // Alternating bit patterns after a reinit
        send_op(MODE_PUSH, SIDE_LOWER, 32'h5555_5555);
        send_op(MODE_PUSH, SIDE_UPPER, 32'hAAAA_AAAA);
        send_op(MODE_PEEK, SIDE_LOWER, $urandom());
        send_op(MODE_PEEK, SIDE_UPPER, $urandom());
        send_op(MODE_INIT, SIDE_LOWER, $urandom());

        // ---- random part, phase 1: sender idles 38%, receiver 64% ----
        send_random_ops(183);
        // Sender pauses until the block has answered everything
        wait_results_drained();

        // ---- phase 2: roles swapped ----
        send_idle_pct = 64;
        recv_idle_pct <= 38;
        send_random_ops(183);
        wait_results_drained();

        // ---- phase 3: full rate on both sides ----
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        send_random_ops(184);

        // Drain, then a few spare edges to catch any stray result
        wait_results_drained();
        repeat (4) @(posedge aclk);

        $display("Covered %0d transfers: %0d reinit, %0d push, %0d pop, %0d peek",
                 ops_sent[MODE_INIT] + ops_sent[MODE_PUSH] + ops_sent[MODE_POP]
                 + ops_sent[MODE_PEEK], ops_sent[MODE_INIT], ops_sent[MODE_PUSH],
                 ops_sent[MODE_POP], ops_sent[MODE_PEEK]);
        $display("Outcomes: %0d overflow, %0d underflow, %0d empty peek, %0d with store full",
                 overflow_hits, underflow_hits, empty_hits, full_hits);
        if (mismatch_count == 0) begin
            $display("[dual_stack_shared_array_top] OK");
        end else begin
            $display("[dual_stack_shared_array_top] ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("[dual_stack_shared_array_top] ERROR");
        $finish;
    end

endmodule

>>> files.f
sv/dss_pkg.sv
sv/dss_ctrl.sv
sv/dss_datapath.sv
sv/dual_stack_shared_array_top.sv
sim/dss_stack_checker.sv
sim/tb_dual_stack_shared_array_top.sv
